[rtl/wav_header_parser_defines.svh]
// ---------------------------------------------------------------------------
// wav_header_parser_defines
// Assertion macros shared by the WAV header parser RTL.
// ---------------------------------------------------------------------------
`ifndef WAV_HEADER_PARSER_DEFINES_SVH
`define WAV_HEADER_PARSER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define WHP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define WHP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/wav_hp_pkg.sv]
// ---------------------------------------------------------------------------
// wav_hp_pkg
// Types and constants for the WAV header parser.
// ---------------------------------------------------------------------------
package wav_hp_pkg;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'd0,
    PH_RIFF   = 5'd1,
    PH_FSIZE  = 5'd2,
    PH_WAVE   = 5'd3,
    PH_FMT    = 5'd4,
    PH_FLEN   = 5'd5,
    PH_FTYPE  = 5'd6,
    PH_CHAN   = 5'd7,
    PH_RATE   = 5'd8,
    PH_BRATE  = 5'd9,
    PH_BALIGN = 5'd10,
    PH_BPS    = 5'd11,
    PH_CID    = 5'd12,
    PH_CSIZE  = 5'd13,
    PH_CSKIP  = 5'd14,
    PH_DSIZE  = 5'd15,
    PH_DATA   = 5'd16,
    PH_DONE   = 5'd17
  } phase_t;

  // result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_AUDIO  = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // error codes
  localparam logic [2:0] ERR_RIFF_WAVE = 3'd0;
  localparam logic [2:0] ERR_NO_FMT    = 3'd1;
  localparam logic [2:0] ERR_FMT_LEN   = 3'd2;
  localparam logic [2:0] ERR_NOT_PCM   = 3'd3;
  localparam logic [2:0] ERR_NEG_SIZE  = 3'd4;

  // format codes
  localparam logic [1:0] FMT_MONO8    = 2'd0;
  localparam logic [1:0] FMT_MONO16   = 2'd1;
  localparam logic [1:0] FMT_STEREO8  = 2'd2;
  localparam logic [1:0] FMT_STEREO16 = 2'd3;

  // little-endian markers as assembled from four bytes
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [23:0] TAG_CUE  = 24'h65_7563;
  localparam logic [31:0] TAG_LIST = 32'h7473_696C;
  localparam logic [31:0] TAG_INFO = 32'h6F66_6E69;
  localparam logic [31:0] TAG_FACT = 32'h7463_6166;

  localparam logic [31:0] FMT_CHUNK_LEN = 32'd16;
  localparam logic [31:0] FMT_TYPE_PCM  = 32'd1;

  localparam int TDATA_W = 112;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] channels;
    logic [31:0] sample_rate;
    logic [15:0] bits_per_sample;
    logic [1:0]  format_code;
    logic [30:0] data_size;
    logic [7:0]  audio_byte;
    logic [2:0]  error_code;
    logic        last;
  } result_t;

endpackage

[rtl/wav_header_parser.sv]
// ---------------------------------------------------------------------------
// wav_header_parser
// Byte-stream parser for RIFF/WAVE PCM headers with audio pass-through.
// ---------------------------------------------------------------------------
//
// Channel  Dir  tdata                                         tuser       tlast
// s_axis   in   [7:0] data_byte                               file_start  -
// m_axis   out  [15:0] channels, [47:16] sample_rate,         kind        last
//               [63:48] bits_per_sample, [65:64] format_code,
//               [96:66] data_size, [104:97] audio_byte,
//               [107:105] error_code, [111:108] zero
//
// One byte per cycle sustained while m_axis is not stalled; each byte is
// held in the input register, then its result is registered in the result
// register and offered on m_axis. The per-byte step (32-bit field assembly,
// a 32-bit and a 31-bit decrement and compare) sits between those two
// registers.
// rst is synchronous: parser returns to waiting for a byte with tuser set.
// A stalled m_axis holds the result; the input register still fills, then
// s_axis_tready drops until the result is taken.
//
`include "wav_header_parser_defines.svh"

module wav_header_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [7:0] data_byte
  input  logic                          s_axis_tuser,   // [0] file_start
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [wav_hp_pkg::TDATA_W-1:0] m_axis_tdata,  // see table above
  output logic [1:0]                    m_axis_tuser,   // [1:0] kind
  output logic                          m_axis_tlast    // last
);
  import wav_hp_pkg::*;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_start;

  // result register
  logic    out_valid;
  result_t out_res;

  // parser state
  phase_t      phase, phase_next;
  logic [1:0]  cnt, cnt_next;
  logic [31:0] shift, shift_next;
  logic [15:0] chan, chan_next;
  logic [31:0] rate, rate_next;
  logic [15:0] bps, bps_next;
  logic [31:0] skip, skip_next;
  logic [30:0] payload, payload_next;

  // step outputs
  logic    res_valid;
  result_t res;

  // effective state after an optional restart
  phase_t      cur_phase;
  logic [1:0]  cur_cnt;
  logic [31:0] cur_shift;
  logic [15:0] cur_chan;
  logic [31:0] cur_rate;
  logic [15:0] cur_bps;
  logic [31:0] cur_skip;
  logic [30:0] cur_payload;

  logic [7:0]  b_fold;
  logic [31:0] asm_val;
  logic        two_byte;
  logic        field_done;
  logic [31:0] skip_dec;
  logic [30:0] payload_dec;

  logic advance;

  // assertion helpers
  logic out_err;      // error result sitting in the result register
  logic err_step;     // error result leaving the step
  logic short_field;  // phase holds a two-byte field

  // the step runs when the input register holds a byte and the result
  // register is free or being emptied
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte  <= s_axis_tdata;
      in_start <= s_axis_tuser;
    end
  end

  always_comb begin
    if (in_start) begin
      cur_phase   = PH_RIFF;
      cur_cnt     = '0;
      cur_shift   = '0;
      cur_chan    = '0;
      cur_rate    = '0;
      cur_bps     = '0;
      cur_skip    = '0;
      cur_payload = '0;
    end else begin
      cur_phase   = phase;
      cur_cnt     = cnt;
      cur_shift   = shift;
      cur_chan    = chan;
      cur_rate    = rate;
      cur_bps     = bps;
      cur_skip    = skip;
      cur_payload = payload;
    end
  end

  // chunk ids compare case-insensitively (ASCII A-Z only)
  assign b_fold = (cur_phase == PH_CID && in_byte >= 8'h41 && in_byte <= 8'h5A)
                ? in_byte + 8'h20 : in_byte;
  assign asm_val  = cur_shift | ({24'h0, b_fold} << {cur_cnt, 3'b000});
  assign two_byte = (cur_phase == PH_FTYPE) || (cur_phase == PH_CHAN) ||
                    (cur_phase == PH_BALIGN) || (cur_phase == PH_BPS);
  assign field_done  = two_byte ? (cur_cnt == 2'd1) : (cur_cnt == 2'd3);
  assign skip_dec    = cur_skip - 32'd1;
  assign payload_dec = cur_payload - 31'd1;

  always_comb begin
    phase_next   = cur_phase;
    cnt_next     = cur_cnt;
    shift_next   = cur_shift;
    chan_next    = cur_chan;
    rate_next    = cur_rate;
    bps_next     = cur_bps;
    skip_next    = cur_skip;
    payload_next = cur_payload;
    res_valid    = 1'b0;
    res          = '0;

    unique case (cur_phase)
      PH_IDLE, PH_DONE: begin
      end
      PH_CSKIP: begin
        skip_next = skip_dec;
        if (skip_dec == 32'd0) begin
          phase_next = PH_CID;
        end
      end
      PH_DATA: begin
        res_valid      = 1'b1;
        res.kind       = KIND_AUDIO;
        res.audio_byte = in_byte;
        payload_next   = payload_dec;
        if (payload_dec == 31'd0) begin
          res.last   = 1'b1;
          phase_next = PH_DONE;
        end
      end
      PH_RIFF, PH_FSIZE, PH_WAVE, PH_FMT, PH_FLEN, PH_FTYPE, PH_CHAN,
      PH_RATE, PH_BRATE, PH_BALIGN, PH_BPS, PH_CID, PH_CSIZE,
      PH_DSIZE: begin
        if (!field_done) begin
          cnt_next   = cur_cnt + 2'd1;
          shift_next = asm_val;
        end else begin
          cnt_next   = '0;
          shift_next = '0;
          unique case (cur_phase)
            PH_RIFF: begin
              if (asm_val != TAG_RIFF) begin
                res_valid      = 1'b1;
                res.kind       = KIND_ERROR;
                res.error_code = ERR_RIFF_WAVE;
                phase_next     = PH_DONE;
              end else begin
                phase_next = PH_FSIZE;
              end
            end
            PH_FSIZE: phase_next = PH_WAVE;
            PH_WAVE: begin
              if (asm_val != TAG_WAVE) begin
                res_valid      = 1'b1;
                res.kind       = KIND_ERROR;
                res.error_code = ERR_RIFF_WAVE;
                phase_next     = PH_DONE;
              end else begin
                phase_next = PH_FMT;
              end
            end
            PH_FMT: begin
              if (asm_val != TAG_FMT) begin
                res_valid      = 1'b1;
                res.kind       = KIND_ERROR;
                res.error_code = ERR_NO_FMT;
                phase_next     = PH_DONE;
              end else begin
                phase_next = PH_FLEN;
              end
            end
            PH_FLEN: begin
              if (asm_val != FMT_CHUNK_LEN) begin
                res_valid      = 1'b1;
                res.kind       = KIND_ERROR;
                res.error_code = ERR_FMT_LEN;
                phase_next     = PH_DONE;
              end else begin
                phase_next = PH_FTYPE;
              end
            end
            PH_FTYPE: begin
              if (asm_val != FMT_TYPE_PCM) begin
                res_valid      = 1'b1;
                res.kind       = KIND_ERROR;
                res.error_code = ERR_NOT_PCM;
                phase_next     = PH_DONE;
              end else begin
                phase_next = PH_CHAN;
              end
            end
            PH_CHAN: begin
              chan_next  = asm_val[15:0];
              phase_next = PH_RATE;
            end
            PH_RATE: begin
              rate_next  = asm_val;
              phase_next = PH_BRATE;
            end
            PH_BRATE:  phase_next = PH_BALIGN;
            PH_BALIGN: phase_next = PH_BPS;
            PH_BPS: begin
              bps_next   = asm_val[15:0];
              phase_next = PH_CID;
            end
            PH_CID: begin
              if (asm_val[23:0] == TAG_CUE || asm_val == TAG_LIST ||
                  asm_val == TAG_INFO || asm_val == TAG_FACT) begin
                phase_next = PH_CSIZE;
              end else begin
                phase_next = PH_DSIZE;
              end
            end
            PH_CSIZE: begin
              // negative or zero size skips nothing
              if (asm_val[31] || asm_val == 32'd0) begin
                phase_next = PH_CID;
              end else begin
                skip_next  = asm_val;
                phase_next = PH_CSKIP;
              end
            end
            PH_DSIZE: begin
              res_valid = 1'b1;
              if (asm_val[31]) begin
                res.kind       = KIND_ERROR;
                res.error_code = ERR_NEG_SIZE;
                phase_next     = PH_DONE;
              end else begin
                payload_next        = asm_val[30:0];
                res.kind            = KIND_HEADER;
                res.channels        = cur_chan;
                res.sample_rate     = cur_rate;
                res.bits_per_sample = cur_bps;
                res.data_size       = asm_val[30:0];
                if (cur_chan == 16'd1) begin
                  res.format_code = (cur_bps == 16'd8) ? FMT_MONO8 : FMT_MONO16;
                end else begin
                  res.format_code = (cur_bps == 16'd8) ? FMT_STEREO8 : FMT_STEREO16;
                end
                if (asm_val == 32'd0) begin
                  res.last   = 1'b1;
                  phase_next = PH_DONE;
                end else begin
                  phase_next = PH_DATA;
                end
              end
            end
            default: phase_next = PH_DONE;
          endcase
        end
      end
      default: phase_next = PH_DONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_IDLE;
      cnt     <= '0;
      shift   <= '0;
      chan    <= '0;
      rate    <= '0;
      bps     <= '0;
      skip    <= '0;
      payload <= '0;
    end else if (advance) begin
      phase   <= phase_next;
      cnt     <= cnt_next;
      shift   <= shift_next;
      chan    <= chan_next;
      rate    <= rate_next;
      bps     <= bps_next;
      skip    <= skip_next;
      payload <= payload_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'h0, out_res.error_code, out_res.audio_byte,
                          out_res.data_size, out_res.format_code,
                          out_res.bits_per_sample, out_res.sample_rate,
                          out_res.channels};
  assign m_axis_tuser  = out_res.kind;
  assign m_axis_tlast  = out_res.last;

  assign out_err     = out_valid && (out_res.kind == KIND_ERROR);
  assign err_step    = advance && res_valid && (res.kind == KIND_ERROR);
  assign short_field = (phase == PH_FTYPE) || (phase == PH_CHAN) ||
                       (phase == PH_BALIGN) || (phase == PH_BPS);

  // errors never carry the last mark
  `WHP_ASSERT_NOW(a_err_not_last, out_err, !out_res.last, "error marked last")
  // an error step always parks the parser
  `WHP_ASSERT_NEXT(a_err_parks, err_step, phase == PH_DONE, "not parked after error")
  // two-byte fields never count past their second byte
  `WHP_ASSERT_NOW(a_short_cnt, short_field, cnt <= 2'd1, "short field count overrun")
  // skip and payload counters are live while their phase is active
  `WHP_ASSERT_NOW(a_skip_live, phase == PH_CSKIP, skip != 32'd0, "empty skip count")
  `WHP_ASSERT_NOW(a_payload_live, phase == PH_DATA, payload != 31'd0, "empty payload count")

endmodule
